// ===== design/fpfl_pkg.sv =====
package fpfl_pkg;

    // Default pool size; the top level takes it as a parameter.
    localparam int CAPACITY_DEF = 1024;

    // Field widths fixed by the request and response formats.
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int LIMIT_W = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOCATE = 2'd0,
        OP_FREE     = 2'd1,
        OP_RESERVE  = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  granted_slot;
        logic [COUNT_W-1:0] shortfall;
    } rsp_t;

endpackage

// ===== design/fpfl_if.sv =====
interface fpfl_req_if
    import fpfl_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpfl_rsp_if
    import fpfl_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/fixed_pool_free_list_core.sv =====
// Free, release and allocate of a fresh slot load the output register as the request is
// taken, if the register is free; allocate from the free list first passes S_ALLOC for the
// link read. Reserve walks free entries in S_WALK, then makes slots and splices in S_MAKE.
// One request at a time: the next request is taken only once the result sits in the output
// register; a result that meets a stalled output waits in S_DONE.
// Reset clears the list head, the created count and sets the limit to 1024; the link memory
// keeps its contents and needs no clearing pass.
module fixed_pool_free_list_core
    import fpfl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    fpfl_req_if.sink           req,
    fpfl_rsp_if.source         rsp
);

    // Address width of the link memory and width of an encoded link (0 = end of list,
    // otherwise slot index + 1). The created count shares the link width.
    localparam int AW    = $clog2(CAPACITY);
    localparam int ENC_W = $clog2(CAPACITY + 1);
    localparam int LW    = (ENC_W > LIMIT_W) ? ENC_W : LIMIT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ALLOC = 5'b00010,
        S_WALK  = 5'b00100,
        S_MAKE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [ENC_W-1:0]   head_reg, head_next;
    logic [ENC_W-1:0]   created_reg, created_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] need_reg, need_next;
    logic [ENC_W-1:0]   tail_reg, tail_next;
    logic [ENC_W-1:0]   rest_reg, rest_next;
    logic               made_reg, made_next;
    rsp_t               res_reg, res_next;
    logic               out_valid_reg;
    rsp_t               out_data_reg;

    // Link memory: one write port and one read port, read data registered.
    logic [ENC_W-1:0] link_mem [CAPACITY];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENC_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [ENC_W-1:0] mem_rdata;

    logic fin;
    rsp_t fin_data;
    logic out_free;
    logic out_load;
    rsp_t out_load_data;
    logic can_create;
    logic free_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= link_mem[mem_raddr];
        end
    end

    // A new slot may be made while the count stays below both the limit register and the
    // pool size; a limit above the pool size acts as the pool size.
    assign can_create = (LW'(created_reg) < LW'(limit_reg)) && (32'(created_reg) < CAPACITY);
    assign free_ok    = (32'(req.data.slot) < CAPACITY);
    assign out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        created_next  = created_reg;
        need_next     = need_reg;
        tail_next     = tail_reg;
        rest_next     = rest_reg;
        made_next     = made_reg;
        res_next      = res_reg;
        fin           = 1'b0;
        fin_data      = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        out_load      = 1'b0;
        out_load_data = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.data.operation)
                        OP_ALLOCATE:
                        begin
                            if (head_reg != '0)
                            begin
                                // Pop the head: its link comes back next cycle.
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(head_reg - ENC_W'(1));
                                state_next = S_ALLOC;
                            end
                            else
                            begin
                                fin = 1'b1;
                                if (can_create)
                                begin
                                    fin_data.granted      = 1'b1;
                                    fin_data.granted_slot = SLOT_W'(created_reg);
                                    created_next          = created_reg + ENC_W'(1);
                                end
                            end
                        end
                        OP_FREE:
                        begin
                            fin = 1'b1;
                            if (free_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(req.data.slot);
                                mem_wdata = head_reg;
                                head_next = ENC_W'(req.data.slot) + ENC_W'(1);
                            end
                        end
                        OP_RESERVE:
                        begin
                            made_next = 1'b0;
                            rest_next = head_reg;
                            if ((req.data.count != '0) && (head_reg != '0))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(head_reg - ENC_W'(1));
                                tail_next  = head_reg;
                                need_next  = req.data.count - COUNT_W'(1);
                                state_next = S_WALK;
                            end
                            else
                            begin
                                tail_next  = '0;
                                need_next  = req.data.count;
                                state_next = S_MAKE;
                            end
                        end
                        default:
                        begin
                            head_next    = '0;
                            created_next = '0;
                            fin          = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                fin                   = 1'b1;
                fin_data.granted      = 1'b1;
                fin_data.granted_slot = SLOT_W'(head_reg - ENC_W'(1));
                head_next             = mem_rdata;
            end
            S_WALK:
            begin
                // The read data is the link of the tail; follow it one entry per cycle.
                rest_next = mem_rdata;
                if ((need_reg != '0) && (mem_rdata != '0))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(mem_rdata - ENC_W'(1));
                    tail_next = mem_rdata;
                    need_next = need_reg - COUNT_W'(1);
                end
                else
                begin
                    state_next = S_MAKE;
                end
            end
            S_MAKE:
            begin
                if ((need_reg != '0) && can_create)
                begin
                    // Append a fresh slot after the tail of the reserved chain.
                    if (tail_reg == '0)
                    begin
                        head_next = created_reg + ENC_W'(1);
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(tail_reg - ENC_W'(1));
                        mem_wdata = created_reg + ENC_W'(1);
                    end
                    tail_next    = created_reg + ENC_W'(1);
                    created_next = created_reg + ENC_W'(1);
                    need_next    = need_reg - COUNT_W'(1);
                    made_next    = 1'b1;
                end
                else
                begin
                    // Splice the unwalked rest of the list behind the new slots.
                    fin                = 1'b1;
                    fin_data.shortfall = need_reg;
                    if (made_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(tail_reg - ENC_W'(1));
                        mem_wdata = rest_reg;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_load      = 1'b1;
                out_load_data = fin_data;
                state_next    = S_IDLE;
            end
            else
            begin
                res_next   = fin_data;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            created_reg   <= '0;
            limit_reg     <= LIMIT_RST;
            need_reg      <= '0;
            tail_reg      <= '0;
            rest_reg      <= '0;
            made_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            created_reg <= created_next;
            need_reg    <= need_next;
            tail_reg    <= tail_next;
            rest_reg    <= rest_next;
            made_reg    <= made_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// ===== design/fpfl_checker.sv =====
module fpfl_checker
    import fpfl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A waiting result holds still until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // A slot number is shown only with a grant.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.granted |-> rsp_data.granted_slot == '0)
        else $error("slot reported without a grant");

    // A grant comes from allocate, a shortfall from reserve; never both.
    a_grant_short: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.granted |-> rsp_data.shortfall == '0)
        else $error("grant and shortfall in one response");

endmodule

bind fixed_pool_free_list_core fpfl_checker u_fpfl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the free-list slot allocator.
//
// Requests go in through the request channel and every request returns exactly one response.
// A local copy of the pool (list head, link memory, created count and slot limit) is advanced
// for each request at the edge where the request is taken. The predicted response is queued,
// and the response checker compares each returned response field by field with the oldest
// queued one.
//
// The run has three parts:
//   - directed requests that cover every operation and the corner cases: double free, free of
//     a slot that was never created (which can close a cycle in the list), zero-count
//     reserve, a zero limit, a limit lowered below the created count, a limit above the
//     capacity, and a full-size reserve;
//   - random traffic, mostly well-formed (slots that are freed were handed out earlier),
//     mixed with stray frees and occasional release-all requests;
//   - a drain, after which the result is printed.
//
// The slot limit is only written while the pool is idle, that is, when no response is
// outstanding.
module tb;
    import fpfl_pkg::*;

    localparam int POOL_SLOTS = CAPACITY_DEF;

    // The slowest legal run is dominated by a handful of full-size reserves. The remaining
    // requests are short, even with heavy stalls, so this cap leaves a wide margin.
    localparam int CYCLE_CAP = 400_000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    fpfl_req_if req_ch ();
    fpfl_rsp_if rsp_ch ();

    fixed_pool_free_list_core #(
        .CAPACITY (POOL_SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Local copy of the pool. List entries are encoded as slot + 1, and 0 marks the end
    // of the list.
    logic [LIMIT_W-1:0] list_head;
    logic [LIMIT_W-1:0] made_slots;
    logic [LIMIT_W-1:0] limit_copy;
    logic [LIMIT_W-1:0] chain [POOL_SLOTS];

    rsp_t pool_answers [$];
    logic [SLOT_W-1:0] held_slots [$];
    int fault_count;
    int send_idle_pct;
    int stall_pct;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [LIMIT_W-1:0] follow(input logic [LIMIT_W-1:0] enc);
        if (enc == '0)
        begin
            return '0;
        end
        return chain[enc - 1'b1];
    endfunction

    // This function advances the local pool by one request and returns the response that
    // the block must give for that request.
    function automatic rsp_t pool_step(input req_t r);
        rsp_t o;
        logic [LIMIT_W-1:0] top;
        logic [LIMIT_W-1:0] tail;
        logic [LIMIT_W-1:0] rest;
        logic [COUNT_W-1:0] need;
        bit made;
        o = '0;
        top = (limit_copy < LIMIT_W'(POOL_SLOTS)) ? limit_copy : LIMIT_W'(POOL_SLOTS);
        case (op_t'(r.operation))
            OP_ALLOCATE:
            begin
                // Take the list head first. A fresh slot is created only when the
                // list is empty.
                if (list_head != '0)
                begin
                    o.granted = 1'b1;
                    o.granted_slot = SLOT_W'(list_head - 1'b1);
                    list_head = follow(list_head);
                end
                else if (made_slots < top)
                begin
                    o.granted = 1'b1;
                    o.granted_slot = SLOT_W'(made_slots);
                    made_slots = made_slots + 1'b1;
                end
            end
            OP_FREE:
            begin
                // The slot is pushed onto the head without any check, so a double free
                // can leave repeats or a cycle in the list.
                chain[r.slot] = list_head;
                list_head = {1'b0, r.slot} + 1'b1;
            end
            OP_RESERVE:
            begin
                // Walk up to the requested number of free entries. Then append fresh
                // slots after the last entry walked and splice the rest of the list
                // back on behind them.
                need = r.count;
                tail = '0;
                rest = list_head;
                made = 1'b0;
                while (need != '0 && rest != '0)
                begin
                    tail = rest;
                    rest = follow(rest);
                    need = need - 1'b1;
                end
                while (need != '0 && made_slots < top)
                begin
                    if (tail == '0)
                    begin
                        list_head = made_slots + 1'b1;
                    end
                    else
                    begin
                        chain[tail - 1'b1] = made_slots + 1'b1;
                    end
                    tail = made_slots + 1'b1;
                    made_slots = made_slots + 1'b1;
                    need = need - 1'b1;
                    made = 1'b1;
                end
                if (made)
                begin
                    chain[tail - 1'b1] = rest;
                end
                o.shortfall = need;
            end
            default:
            begin
                list_head = '0;
                made_slots = '0;
            end
        endcase
        return o;
    endfunction

    // This task sends one request, optionally after an idle gap. It waits for the handshake
    // and then queues the predicted response. Valid stays high on return, so back-to-back
    // requests never lower and raise it in the same time step.
    task automatic issue(input op_t op, input int slot_idx, input int cnt, output rsp_t predicted);
        req_t r;
        r.operation = op;
        r.slot = SLOT_W'(slot_idx);
        r.count = COUNT_W'(cnt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = pool_step(r);
        pool_answers.push_back(predicted);
    endtask

    // This task drops valid and waits until every outstanding response has come back,
    // which leaves the block idle. With nothing outstanding, valid is already low.
    task automatic settle_pool();
        if (pool_answers.size() != 0)
        begin
            req_ch.valid <= 1'b0;
        end
        while (pool_answers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_slot_limit(input int value);
        settle_pool();
        cfg_wdata <= LIMIT_W'(value);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_copy = LIMIT_W'(value);
    endtask

    // This test sends every operation at least once. It also covers a double free and a free of a
    // slot that was never created, which together close a cycle in the list. A reserve then
    // walks that cycle.
    task automatic test_basic_ops();
        rsp_t got;
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_RESERVE, 1023, 0, got);
        issue(OP_FREE, 0, 1024, got);
        issue(OP_FREE, 1023, 0, got);
        issue(OP_FREE, 0, 2047, got);
        issue(OP_RESERVE, 0, 5, got);
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_ALLOCATE, 1023, 1024, got);
        issue(OP_RELEASE, 1023, 1024, got);
        issue(OP_FREE, 682, 0, got);
        issue(OP_FREE, 341, 0, got);
        issue(OP_ALLOCATE, 0, 0, got);
    endtask

    // This test covers a zero limit, a limit of one, a limit lowered below the created count,
    // and a limit above the capacity. The last case is exercised with a full-size reserve.
    task automatic test_limit_extremes();
        rsp_t got;
        set_slot_limit(0);
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_RESERVE, 0, 3, got);
        issue(OP_FREE, 5, 0, got);
        issue(OP_ALLOCATE, 0, 0, got);
        set_slot_limit(1);
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_ALLOCATE, 0, 0, got);
        set_slot_limit(POOL_SLOTS);
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_ALLOCATE, 0, 0, got);
        set_slot_limit(2);
        issue(OP_ALLOCATE, 0, 0, got);
        issue(OP_RESERVE, 0, 1, got);
        set_slot_limit(2047);
        issue(OP_RESERVE, 0, 1024, got);
        issue(OP_ALLOCATE, 0, 0, got);
    endtask

    // This test sends random traffic. Most requests are well formed: frees return slots
    // that were handed out earlier, and reserves are mostly small. The rest are stray frees
    // of random slots, rare reserves of up to the full size and release-all requests. Fields that an
    // operation ignores carry random values.
    task automatic test_random_traffic(input int sidle, input int rstall, input int lim,
                                       input int n, input bit fresh);
        rsp_t got;
        int pick;
        int idx;
        int slot_idx;
        set_slot_limit(lim);
        send_idle_pct = sidle;
        stall_pct = rstall;
        if (fresh)
        begin
            issue(OP_RELEASE, $urandom_range(1023), $urandom_range(1024), got);
            held_slots.delete();
        end
        repeat (n)
        begin
            // Now and then the sender holds off until the pool has answered everything.
            if ($urandom_range(49) == 0)
            begin
                settle_pool();
            end
            pick = $urandom_range(99);
            if (pick < 42)
            begin
                issue(OP_ALLOCATE, $urandom_range(1023), $urandom_range(1024), got);
                if (got.granted)
                begin
                    held_slots.push_back(got.granted_slot);
                end
            end
            else if (pick < 72)
            begin
                if (held_slots.size() != 0 && $urandom_range(9) != 0)
                begin
                    idx = $urandom_range(held_slots.size() - 1);
                    slot_idx = held_slots[idx];
                    held_slots.delete(idx);
                end
                else
                begin
                    slot_idx = $urandom_range(1023);
                end
                issue(OP_FREE, slot_idx, $urandom_range(1024), got);
            end
            else if (pick < 97)
            begin
                issue(OP_RESERVE, $urandom_range(1023),
                      ($urandom_range(39) == 0) ? $urandom_range(1024) : $urandom_range(8),
                      got);
            end
            else
            begin
                issue(OP_RELEASE, $urandom_range(1023), $urandom_range(1024), got);
                held_slots.delete();
            end
        end
    endtask

    // The response checker also drives ready, stalling at random at the current rate.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pool_answers.size() == 0)
            begin
                $error("response with no request outstanding: %p", rsp_ch.data);
                fault_count++;
            end
            else
            begin
                want = pool_answers.pop_front();
                if (rsp_ch.data.granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, rsp_ch.data.granted);
                    fault_count++;
                end
                if (rsp_ch.data.granted_slot !== want.granted_slot)
                begin
                    $error("granted_slot: expected %0d, got %0d",
                           want.granted_slot, rsp_ch.data.granted_slot);
                    fault_count++;
                end
                if (rsp_ch.data.shortfall !== want.shortfall)
                begin
                    $error("shortfall: expected %0d, got %0d",
                           want.shortfall, rsp_ch.data.shortfall);
                    fault_count++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        fault_count = 0;
        cycle_count = 0;
        send_idle_pct = 21;
        stall_pct = 64;
        list_head = '0;
        made_slots = '0;
        limit_copy = LIMIT_RST;
        foreach (chain[i])
        begin
            chain[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_limit_extremes();

        // Light sender gaps against a slow receiver come first, then the reverse, and
        // finally full speed on both sides. The limit changes between phases, and the
        // state carries over so that a lowered limit meets slots created earlier.
        test_random_traffic(21, 64, POOL_SLOTS, 150, 1'b1);
        test_random_traffic(21, 64, 16, 130, 1'b0);
        test_random_traffic(64, 21, 2047, 150, 1'b0);
        test_random_traffic(64, 21, 0, 90, 1'b0);
        test_random_traffic(0, 0, 1, 100, 1'b0);
        test_random_traffic(0, 0, POOL_SLOTS, 230, 1'b0);

        // Keep the clock running after the drain so that a stray extra response would be seen.
        settle_pool();
        repeat (20) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
